// File: rtl/lccs_pkg.sv
// Shared constants, codes and control/status types of the lazy-cleared cell store.
package lccs_pkg;

  // Store geometry.
  localparam int ROWS = 1024;
  localparam int COLS = 256;

  // Row and column widths of the stored high-water marks.
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

  // Cell memory: one 128-bit word per row and column.
  localparam longint CELLS  = longint'(ROWS) * longint'(COLS);
  localparam int     CELL_AW = $clog2(CELLS);
  localparam int     CELL_W  = 128;

  // Row live bits are kept 32 to a memory word.
  localparam int LIVE_BW = 5;
  localparam int LIVE_W  = 1 << LIVE_BW;
  localparam int LIVE_D  = (ROWS + LIVE_W - 1) / LIVE_W;
  localparam int LIVE_AW = (LIVE_D > 1) ? $clog2(LIVE_D) : 1;

  // One sweep counter serves both the row clear and the live-bit clear.
  localparam int CNT_COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int CNT_LIVE_W = (LIVE_D > 1) ? $clog2(LIVE_D) : 1;
  localparam int CNT_W      = (CNT_COL_W > CNT_LIVE_W) ? CNT_COL_W : CNT_LIVE_W;

  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_PUT   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_SWEEP_LIVE,
    ST_IDLE,
    ST_DECIDE,
    ST_SWEEP_ROW,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;      // take the input beat and issue both memory reads
    logic live_clr_wr;  // write a zero live word at the sweep count
    logic row_clr_wr;   // write a zero cell at row base plus sweep count
    logic commit;       // write the put cell, set the live bit, update marks
    logic mark_clear;   // forget the marks and the written flag
    logic cnt_clr;
    logic cnt_inc;
    logic out_load;     // load the result register
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_range;
    logic live_hit;
    logic row_last;
    logic live_last;
  } dp_sts_t;

endpackage

// File: rtl/lccs_dp.sv
// Datapath of the lazy-cleared cell store: memories, sweep counter, marks and result register.
module lccs_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lccs_pkg::dp_cmd_t      cmd,
  output lccs_pkg::dp_sts_t      sts,
  input  logic [1:0]             in_op,
  input  logic [15:0]            in_row,
  input  logic [15:0]            in_col,
  input  logic [63:0]            in_wr_lo,
  input  logic [63:0]            in_wr_hi,
  output logic [63:0]            out_rd_lo,
  output logic [63:0]            out_rd_hi,
  output logic                   out_row_empty,
  output logic [9:0]             out_high_row,
  output logic [7:0]             out_high_col,
  output logic                   out_anything_written
);

  logic [lccs_pkg::CELL_W-1:0]  cell_mem_r [lccs_pkg::CELLS];
  logic [lccs_pkg::LIVE_W-1:0]  live_mem_r [lccs_pkg::LIVE_D];

  lccs_pkg::op_t                op_r;
  logic                         row_ok_r;
  logic                         in_range_r;
  logic [lccs_pkg::LIVE_BW-1:0] bit_r;
  logic [lccs_pkg::LIVE_AW-1:0] live_addr_r, live_addr_nxt;
  logic [lccs_pkg::CELL_AW-1:0] cell_addr_r, cell_addr_nxt;
  logic [lccs_pkg::CELL_AW-1:0] base_r;
  logic [lccs_pkg::CELL_W-1:0]  wr_data_r;
  logic [lccs_pkg::ROW_W-1:0]   row_r;
  logic [lccs_pkg::COL_W-1:0]   col_r;
  logic [lccs_pkg::CELL_W-1:0]  cell_rd_r;
  logic [lccs_pkg::LIVE_W-1:0]  live_rd_r;
  logic [lccs_pkg::CNT_W-1:0]   cnt_r;
  logic [lccs_pkg::ROW_W-1:0]   mark_row_r, mark_row_nxt;
  logic [lccs_pkg::COL_W-1:0]   mark_col_r, mark_col_nxt;
  logic                         flag_r, flag_nxt;

  logic [31:0]                  prod;
  logic                         row_ok;
  logic                         col_ok;
  logic                         live_hit;
  logic                         live_we;
  logic [lccs_pkg::LIVE_AW-1:0] live_wa;
  logic [lccs_pkg::LIVE_W-1:0]  live_wd;
  logic                         cell_we;
  logic [lccs_pkg::CELL_AW-1:0] cell_wa;
  logic [lccs_pkg::CELL_W-1:0]  cell_wd;
  logic [lccs_pkg::CELL_W-1:0]  rd_sel;
  logic                         empty_sel;

  // Address generation straight from the input beat.
  always_comb begin
    prod          = 32'(in_row) * 32'(lccs_pkg::COLS);
    row_ok        = 32'(in_row) < 32'(lccs_pkg::ROWS);
    col_ok        = 32'(in_col) < 32'(lccs_pkg::COLS);
    live_addr_nxt = lccs_pkg::LIVE_AW'(in_row >> lccs_pkg::LIVE_BW);
    cell_addr_nxt = lccs_pkg::CELL_AW'(prod + 32'(in_col));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= lccs_pkg::op_t'(in_op);
      row_ok_r    <= row_ok;
      in_range_r  <= row_ok && col_ok;
      bit_r       <= in_row[lccs_pkg::LIVE_BW-1:0];
      live_addr_r <= live_addr_nxt;
      cell_addr_r <= cell_addr_nxt;
      base_r      <= lccs_pkg::CELL_AW'(prod);
      wr_data_r   <= {in_wr_hi, in_wr_lo};
      row_r       <= lccs_pkg::ROW_W'(in_row);
      col_r       <= lccs_pkg::COL_W'(in_col);
    end
  end

  // Both memories are read once per beat, on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      live_rd_r <= live_mem_r[live_addr_nxt];
      cell_rd_r <= cell_mem_r[cell_addr_nxt];
    end
  end

  always_comb begin
    live_we = cmd.live_clr_wr | cmd.commit;
    live_wa = cmd.live_clr_wr ? lccs_pkg::LIVE_AW'(cnt_r) : live_addr_r;
    live_wd = cmd.live_clr_wr ? '0
                              : (live_rd_r | (lccs_pkg::LIVE_W'(1) << bit_r));
    cell_we = cmd.row_clr_wr | cmd.commit;
    cell_wa = cmd.row_clr_wr ? lccs_pkg::CELL_AW'(base_r + lccs_pkg::CELL_AW'(cnt_r))
                             : cell_addr_r;
    cell_wd = cmd.row_clr_wr ? '0 : wr_data_r;
  end

  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem_r[live_wa] <= live_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem_r[cell_wa] <= cell_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + lccs_pkg::CNT_W'(1);
    end
  end

  // The first successful put after a clear takes its own row and column;
  // later puts only raise the marks.
  always_comb begin
    mark_row_nxt = mark_row_r;
    mark_col_nxt = mark_col_r;
    flag_nxt     = flag_r;
    if (cmd.mark_clear) begin
      mark_row_nxt = '0;
      mark_col_nxt = '0;
      flag_nxt     = 1'b0;
    end else if (cmd.commit) begin
      flag_nxt = 1'b1;
      if (!flag_r) begin
        mark_row_nxt = row_r;
        mark_col_nxt = col_r;
      end else begin
        if (row_r > mark_row_r) begin
          mark_row_nxt = row_r;
        end
        if (col_r > mark_col_r) begin
          mark_col_nxt = col_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_row_r <= '0;
      mark_col_r <= '0;
      flag_r     <= 1'b0;
    end else begin
      mark_row_r <= mark_row_nxt;
      mark_col_r <= mark_col_nxt;
      flag_r     <= flag_nxt;
    end
  end

  always_comb begin
    live_hit  = live_rd_r[bit_r];
    rd_sel    = ((op_r == lccs_pkg::OP_GET) && in_range_r && live_hit) ? cell_rd_r : '0;
    empty_sel = (op_r == lccs_pkg::OP_CLEAR) || !row_ok_r ||
                !(live_hit || ((op_r == lccs_pkg::OP_PUT) && in_range_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rd_lo            <= rd_sel[63:0];
      out_rd_hi            <= rd_sel[127:64];
      out_row_empty        <= empty_sel;
      out_high_row         <= 10'(mark_row_nxt);
      out_high_col         <= 8'(mark_col_nxt);
      out_anything_written <= flag_nxt;
    end
  end

  always_comb begin
    sts.op        = op_r;
    sts.in_range  = in_range_r;
    sts.live_hit  = live_hit;
    sts.row_last  = cnt_r == lccs_pkg::CNT_W'(lccs_pkg::COLS - 1);
    sts.live_last = cnt_r == lccs_pkg::CNT_W'(lccs_pkg::LIVE_D - 1);
  end

endmodule

// File: rtl/lccs_ctrl.sv
// Controller state machine of the lazy-cleared cell store.
module lccs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output lccs_pkg::dp_cmd_t  cmd,
  input  lccs_pkg::dp_sts_t  sts
);

  lccs_pkg::state_t state_r, state_nxt;
  logic             for_clear_r, for_clear_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    for_clear_nxt = for_clear_r;
    case (state_r)
      lccs_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = lccs_pkg::ST_DECIDE;
        end
      end
      lccs_pkg::ST_DECIDE: begin
        case (sts.op)
          lccs_pkg::OP_CLEAR: begin
            state_nxt     = lccs_pkg::ST_SWEEP_LIVE;
            for_clear_nxt = 1'b1;
          end
          lccs_pkg::OP_PUT: begin
            if (sts.in_range && !sts.live_hit) begin
              state_nxt = lccs_pkg::ST_SWEEP_ROW;
            end else begin
              state_nxt = slot_free ? lccs_pkg::ST_IDLE : lccs_pkg::ST_DONE;
            end
          end
          default: begin
            state_nxt = slot_free ? lccs_pkg::ST_IDLE : lccs_pkg::ST_DONE;
          end
        endcase
      end
      lccs_pkg::ST_SWEEP_ROW: begin
        if (sts.row_last) begin
          state_nxt = lccs_pkg::ST_WRITE;
        end
      end
      lccs_pkg::ST_WRITE: begin
        state_nxt = slot_free ? lccs_pkg::ST_IDLE : lccs_pkg::ST_DONE;
      end
      lccs_pkg::ST_SWEEP_LIVE: begin
        if (sts.live_last) begin
          state_nxt     = for_clear_r ? lccs_pkg::ST_DONE : lccs_pkg::ST_IDLE;
          for_clear_nxt = 1'b0;
        end
      end
      lccs_pkg::ST_DONE: begin
        if (slot_free) begin
          state_nxt = lccs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lccs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      lccs_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      lccs_pkg::ST_DECIDE: begin
        case (sts.op)
          lccs_pkg::OP_CLEAR: begin
            cmd.mark_clear = 1'b1;
            cmd.cnt_clr    = 1'b1;
          end
          lccs_pkg::OP_PUT: begin
            if (sts.in_range && !sts.live_hit) begin
              cmd.cnt_clr = 1'b1;
            end else begin
              cmd.commit   = sts.in_range;
              cmd.out_load = slot_free;
            end
          end
          default: begin
            cmd.out_load = slot_free;
          end
        endcase
      end
      lccs_pkg::ST_SWEEP_ROW: begin
        cmd.row_clr_wr = 1'b1;
        cmd.cnt_inc    = 1'b1;
      end
      lccs_pkg::ST_WRITE: begin
        cmd.commit   = 1'b1;
        cmd.out_load = slot_free;
      end
      lccs_pkg::ST_SWEEP_LIVE: begin
        cmd.live_clr_wr = 1'b1;
        cmd.cnt_inc     = 1'b1;
      end
      lccs_pkg::ST_DONE: begin
        cmd.out_load = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lccs_pkg::ST_SWEEP_LIVE;
      for_clear_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      for_clear_r <= for_clear_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/lazy_cleared_cell_store.sv
// Top level of the lazy-cleared cell store: controller plus datapath.
//
// A store of 1024 rows by 256 columns of 128-bit cells with one live bit per
// row, serving one operation beat at a time. For a get, a query, a put to a
// row that is already live and an out-of-range put, the beat is accepted
// while both memories are read; in the next cycle the result is decided,
// any write is made and the result register is loaded, or loaded later if
// an earlier result still waits on out_stall. The first put to a row that
// is not live waits while the single write port of the cell memory zeroes
// the row one cell per cycle before the new cell is written. A clear-all
// sweeps the live bits, kept 32 to a word in a small memory cleared one
// word per cycle. The same pass runs after reset, with in_stall high from
// the release of rst_n until every live word is cleared. The result register
// lets the block take the next input beat while a finished beat still waits
// on out_stall; a result is held until it is taken. Marks and the written
// flag in each result are the values after that beat's operation.
module lazy_cleared_cell_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_row,
  input  logic [15:0] in_col,
  input  logic [63:0] in_wr_lo,
  input  logic [63:0] in_wr_hi,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_rd_lo,
  output logic [63:0] out_rd_hi,
  output logic        out_row_empty,
  output logic [9:0]  out_high_row,
  output logic [7:0]  out_high_col,
  output logic        out_anything_written
);

  // Commands flow from the controller to the datapath, status flows back.
  lccs_pkg::dp_cmd_t cmd;
  lccs_pkg::dp_sts_t sts;

  lccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath owns the cell memory, the live-bit memory, the sweep
  // counter, the high-water marks and the output payload register.
  lccs_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_op                (in_op),
    .in_row               (in_row),
    .in_col               (in_col),
    .in_wr_lo             (in_wr_lo),
    .in_wr_hi             (in_wr_hi),
    .out_rd_lo            (out_rd_lo),
    .out_rd_hi            (out_rd_hi),
    .out_row_empty        (out_row_empty),
    .out_high_row         (out_high_row),
    .out_high_col         (out_high_col),
    .out_anything_written (out_anything_written)
  );

endmodule
